/* src/circular_byte_queue_macros.svh */
// Assertion macros for the circular byte queue.
// Taken in by the top level; no other dependencies.
`ifndef CIRCULAR_BYTE_QUEUE_MACROS_SVH
`define CIRCULAR_BYTE_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define CBQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define CBQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/cbq_pkg.sv */
// Shared types, constants and helpers of the circular byte queue.
// No dependencies; used by every module of the block.
`default_nettype none

package cbq_pkg;

   // Ring geometry and transfer limits
   localparam int DEPTH       = 1024;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = 11;
   localparam int MAX_XFER    = 64;
   localparam int XFER_W      = 7;
   localparam int BYTE_W      = 8;

   // Result buffer
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_LVL_W   = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      FUNC_INSERT   = 2'd0,
      FUNC_RETRIEVE = 2'd1,
      FUNC_PEEK     = 2'd2,
      FUNC_CLEAR    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_BAD   = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // One result beat
   typedef struct packed {
      status_type              status;
      logic [BYTE_W-1:0]       read_byte;
      logic                    last;
      logic [CNT_W-1:0]        used_count;
      logic [CNT_W-1:0]        free_count;
   } rsp_type;

   // Push into the result buffer
   typedef struct packed {
      logic    valid;
      rsp_type beat;
   } push_type;

   // Ring memory access
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [BYTE_W-1:0] wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } ram_cmd_type;

   // Limit a capacity write to 1..DEPTH
   function automatic logic [CNT_W-1:0] clamp_capacity(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > CNT_W'(DEPTH)) begin
         r = CNT_W'(DEPTH);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/cbq_ring_ram.sv */
// Ring storage of the byte queue: one write port, one read port, registered read.
// Depends on cbq_pkg.
`default_nettype none

module cbq_ring_ram (
   input  logic                          clock,
   input  cbq_pkg::ram_cmd_type          cmd,
   output logic [cbq_pkg::BYTE_W-1:0]    rdata
);
   import cbq_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (cmd.re) begin
         rdata_ff <= mem[cmd.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/cbq_rsp_buf.sv */
// Small result FIFO in flops between the controller and the result port.
// Depends on cbq_pkg.
`default_nettype none

module cbq_rsp_buf (
   input  logic                             clock,
   input  logic                             reset,
   input  cbq_pkg::push_type                push,
   output logic [cbq_pkg::RSP_LVL_W-1:0]    level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cbq_pkg::rsp_type                 rsp_beat
);
   import cbq_pkg::*;

   rsp_type               slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_LVL_W-1:0]  level_ff, level_in;
   logic                  pop;

   // pointer and fill bookkeeping
   always_comb begin
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = push.valid ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + RSP_LVL_W'(push.valid) - RSP_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.beat;
      end
   end

   assign level     = level_ff;
   assign rsp_valid = (level_ff != '0);
   assign rsp_beat  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* src/cbq_ctrl.sv */
// Queue controller: pointers, counts, burst tracking and the read sweep.
// Depends on cbq_pkg; drives cbq_ring_ram and cbq_rsp_buf.
`default_nettype none

module cbq_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_func,
   input  logic [cbq_pkg::XFER_W-1:0]        req_count,
   input  logic [cbq_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                              req_first,
   input  logic                              csr_valid,
   input  logic [cbq_pkg::CNT_W-1:0]         csr_capacity,
   input  logic [cbq_pkg::RSP_LVL_W-1:0]     buf_level,
   output cbq_pkg::ram_cmd_type              ram_cmd,
   input  logic [cbq_pkg::BYTE_W-1:0]        ram_rdata,
   output cbq_pkg::push_type                 push
);
   import cbq_pkg::*;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   wi_ff, wi_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic               acc_ff, acc_in;
   logic [XFER_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [XFER_W-1:0]  rd_left_ff, rd_left_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               rd_last_ff, rd_last_in;

   func_type           func;
   logic               accept;
   logic               issue;
   logic               count_bad;
   logic               read_go;
   logic               do_store;
   logic [XFER_W-1:0]  rem_eff;
   logic               imm_push;
   status_type         imm_status;
   logic [IDX_W-1:0]   wi_wr;
   logic [CNT_W-1:0]   wi_next;
   logic [CNT_W-1:0]   rd_start;
   logic [CNT_W-1:0]   rd_next;

   assign func      = func_type'(req_func);
   assign accept    = req_valid && req_ready;
   assign count_bad = (req_count == '0) || (req_count > XFER_W'(MAX_XFER));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (read_go) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (issue && rd_left_ff == XFER_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs: take items only between sweeps and never beside a
   // capacity write; issue reads while the result buffer can absorb them,
   // counting the one in flight
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rd_pend_ff && !csr_valid &&
                        (buf_level < RSP_LVL_W'(RSP_DEPTH));
         end
         ST_READ: begin
            issue = (buf_level + RSP_LVL_W'(rd_pend_ff)) < RSP_LVL_W'(RSP_DEPTH);
         end
         default: ;
      endcase
   end

   // pointer helpers
   always_comb begin
      wi_wr   = (CNT_W'(wi_ff) >= cap_ff) ? '0 : wi_ff;
      wi_next = CNT_W'(wi_wr) + CNT_W'(1);
      if (used_ff <= CNT_W'(wi_ff)) begin
         rd_start = CNT_W'(wi_ff) - used_ff;
      end else begin
         rd_start = cap_ff - used_ff + CNT_W'(wi_ff);
      end
      if (rd_start >= cap_ff) begin
         rd_start = '0;
      end
      rd_next = CNT_W'(rd_ptr_ff) + CNT_W'(1);
   end

   // request decode and counter updates
   always_comb begin
      wi_in      = wi_ff;
      used_in    = used_ff;
      cap_in     = cap_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      rd_ptr_in  = rd_ptr_ff;
      rd_left_in = rd_left_ff;
      rd_pend_in = issue;
      rd_last_in = rd_last_ff;
      read_go    = 1'b0;
      do_store   = 1'b0;
      rem_eff    = rem_ff;
      imm_push   = 1'b0;
      imm_status = STAT_OK;

      if (csr_valid) begin
         // capacity write re-initializes the queue
         cap_in  = clamp_capacity(csr_capacity);
         wi_in   = '0;
         used_in = '0;
         acc_in  = 1'b0;
         rem_in  = '0;
      end else if (accept) begin
         imm_push = 1'b1;
         unique case (func)
            FUNC_INSERT: begin
               if (req_first) begin
                  acc_in = 1'b0;
                  rem_in = '0;
                  if (count_bad) begin
                     imm_status = STAT_BAD;
                  end else if (CNT_W'(req_count) > cap_ff - used_ff) begin
                     imm_status = STAT_FULL;
                  end else begin
                     do_store = 1'b1;
                     rem_eff  = req_count;
                  end
               end else if (acc_ff && rem_ff != '0) begin
                  do_store = 1'b1;
               end else begin
                  imm_status = STAT_BAD;
               end
            end
            FUNC_CLEAR: begin
               wi_in   = '0;
               used_in = '0;
               acc_in  = 1'b0;
               rem_in  = '0;
            end
            FUNC_RETRIEVE, FUNC_PEEK: begin
               if (count_bad) begin
                  imm_status = STAT_BAD;
               end else if (CNT_W'(req_count) > used_ff) begin
                  imm_status = STAT_EMPTY;
               end else begin
                  imm_push   = 1'b0;
                  read_go    = 1'b1;
                  rd_left_in = req_count;
                  rd_ptr_in  = IDX_W'(rd_start);
                  if (func == FUNC_RETRIEVE) begin
                     used_in = used_ff - CNT_W'(req_count);
                  end
               end
            end
            default: ;
         endcase

         // byte goes into the ring; room was reserved on the first byte
         if (do_store) begin
            wi_in   = (wi_next >= cap_ff) ? '0 : IDX_W'(wi_next);
            if (used_ff < cap_ff) begin
               used_in = used_ff + CNT_W'(1);
            end
            rem_in  = rem_eff - XFER_W'(1);
            acc_in  = (rem_eff != XFER_W'(1));
         end
      end

      // read sweep, one byte per issue
      if (issue) begin
         rd_ptr_in  = (rd_next >= cap_ff) ? '0 : IDX_W'(rd_next);
         rd_left_in = rd_left_ff - XFER_W'(1);
         rd_last_in = (rd_left_ff == XFER_W'(1));
      end
   end

   // ring port
   always_comb begin
      ram_cmd.we    = do_store;
      ram_cmd.waddr = wi_wr;
      ram_cmd.wdata = req_data_byte;
      ram_cmd.re    = issue;
      ram_cmd.raddr = rd_ptr_ff;
   end

   // result beat: immediate status or returning ring byte
   always_comb begin
      push.valid           = imm_push || rd_pend_ff;
      push.beat.status     = rd_pend_ff ? STAT_OK : imm_status;
      push.beat.read_byte  = rd_pend_ff ? ram_rdata : '0;
      push.beat.last       = rd_pend_ff ? rd_last_ff : 1'b1;
      push.beat.used_count = used_in;
      push.beat.free_count = cap_in - used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wi_ff      <= '0;
         used_ff    <= '0;
         cap_ff     <= clamp_capacity(CNT_W'(DEPTH));
         acc_ff     <= 1'b0;
         rem_ff     <= '0;
         rd_left_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wi_ff      <= wi_in;
         used_ff    <= used_in;
         cap_ff     <= cap_in;
         acc_ff     <= acc_in;
         rem_ff     <= rem_in;
         rd_left_ff <= rd_left_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   // sweep payload, no reset
   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      rd_last_ff <= rd_last_in;
   end

endmodule

`default_nettype wire

/* src/circular_byte_queue.sv */
// Byte FIFO held in a ring of configurable capacity. Insert, clear and
// rejected requests answer with one beat each; a retrieve or peek of N
// bytes sweeps the ring memory at one byte per cycle while the result buffer
// has room, and holds off new requests until the sweep is done and the last
// byte has come back through the registered read of the ring RAM. A
// four-beat result buffer decouples the result port, so requests keep flowing
// while a few results wait. Requests are held off while a capacity write is
// offered. Writing capacity (limited to 1..1024) empties the queue; the ring
// RAM needs no clearing pass after reset.
// Depends on cbq_pkg, cbq_ring_ram, cbq_rsp_buf, cbq_ctrl and the macro header.
`default_nettype none
`include "circular_byte_queue_macros.svh"

module circular_byte_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [cbq_pkg::XFER_W-1:0]    req_count,
   input  logic [cbq_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                          req_first,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [cbq_pkg::BYTE_W-1:0]    rsp_read_byte,
   output logic                          rsp_last,
   output logic [cbq_pkg::CNT_W-1:0]     rsp_used_count,
   output logic [cbq_pkg::CNT_W-1:0]     rsp_free_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cbq_pkg::CNT_W-1:0]     csr_capacity
);
   import cbq_pkg::*;

   ram_cmd_type           ram_cmd;
   logic [BYTE_W-1:0]     ram_rdata;
   push_type              push;
   logic [RSP_LVL_W-1:0]  buf_level;
   rsp_type               rsp_beat;

   assign csr_ready = 1'b1;

   cbq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_count     (req_count),
      .req_data_byte (req_data_byte),
      .req_first     (req_first),
      .csr_valid     (csr_valid),
      .csr_capacity  (csr_capacity),
      .buf_level     (buf_level),
      .ram_cmd       (ram_cmd),
      .ram_rdata     (ram_rdata),
      .push          (push)
   );

   cbq_ring_ram u_ring (
      .clock (clock),
      .cmd   (ram_cmd),
      .rdata (ram_rdata)
   );

   cbq_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .level     (buf_level),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   // result port
   assign rsp_status     = rsp_beat.status;
   assign rsp_read_byte  = rsp_beat.read_byte;
   assign rsp_last       = rsp_beat.last;
   assign rsp_used_count = rsp_beat.used_count;
   assign rsp_free_count = rsp_beat.free_count;

   // checks
   `CBQ_ASSERT_IMP(a_no_overflow, clock, reset, push.valid, buf_level < RSP_LVL_W'(RSP_DEPTH), "result buffer overflow")
   `CBQ_ASSERT_IMP(a_counts_sane, clock, reset, rsp_valid, ({1'b0, rsp_used_count} + {1'b0, rsp_free_count}) <= (CNT_W + 1)'(DEPTH), "used plus free exceeds ring depth")
   `CBQ_ASSERT_NXT(a_quick_answer, clock, reset, req_valid && req_ready && req_func != FUNC_RETRIEVE && req_func != FUNC_PEEK, rsp_valid, "single-beat request left no result")

endmodule

`default_nettype wire

/* test/circular_byte_queue_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the circular byte queue: watches request, result and capacity beats,
// keeps its own model of the ring and checks every result beat field by field.
// Depends on cbq_pkg for widths and for the function and status codes.
module circular_byte_queue_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [1:0]                   req_func,
   input  logic [cbq_pkg::XFER_W-1:0]   req_count,
   input  logic [cbq_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                         req_first,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [1:0]                   rsp_status,
   input  logic [cbq_pkg::BYTE_W-1:0]   rsp_read_byte,
   input  logic                         rsp_last,
   input  logic [cbq_pkg::CNT_W-1:0]    rsp_used_count,
   input  logic [cbq_pkg::CNT_W-1:0]    rsp_free_count,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [cbq_pkg::CNT_W-1:0]    csr_capacity,
   output int                           mismatches,
   output int                           pending
);
   import cbq_pkg::*;

   typedef struct {
      status_type         status;
      logic [BYTE_W-1:0]  read_byte;
      logic               last;
      logic [CNT_W-1:0]   used_count;
      logic [CNT_W-1:0]   free_count;
   } queue_beat_type;

   // result beats still owed by the block, oldest first
   queue_beat_type expected_beats[$];

   // shadow copy of the queue
   logic [BYTE_W-1:0] ring_bytes [DEPTH];
   logic [CNT_W-1:0]  capacity_now;
   logic [CNT_W-1:0]  write_pos;
   logic [CNT_W-1:0]  used_now;
   logic              burst_open;
   logic [XFER_W-1:0] burst_left;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic empty_ring();
      write_pos  = '0;
      used_now   = '0;
      burst_open = 1'b0;
      burst_left = '0;
   endtask

   task automatic owe_beat(input status_type s, input logic [BYTE_W-1:0] b, input logic l);
      queue_beat_type beat;
      beat.status     = s;
      beat.read_byte  = b;
      beat.last       = l;
      beat.used_count = used_now;
      beat.free_count = capacity_now - used_now;
      expected_beats.push_back(beat);
   endtask

   // write one burst byte at the write position and wrap at capacity
   task automatic store_byte(input logic [BYTE_W-1:0] d);
      logic [CNT_W-1:0] wi;
      wi = write_pos;
      if (wi >= capacity_now) begin
         wi = '0;
      end
      ring_bytes[wi[IDX_W-1:0]] = d;
      wi = wi + 1'b1;
      if (wi >= capacity_now) begin
         wi = '0;
      end
      write_pos = wi;
      if (used_now < capacity_now) begin
         used_now = used_now + 1'b1;
      end
      if (burst_left != '0) begin
         burst_left = burst_left - 1'b1;
      end
      if (burst_left == '0) begin
         burst_open = 1'b0;
      end
   endtask

   // work out the result beats of one accepted request beat
   task automatic apply_request(input func_type f, input logic [XFER_W-1:0] cnt,
                                input logic [BYTE_W-1:0] d, input logic fst);
      logic [CNT_W-1:0]  rd;
      logic [BYTE_W-1:0] got [MAX_XFER];
      int                i;
      unique case (f)
         FUNC_INSERT: begin
            if (fst) begin
               // a first byte always closes the open burst
               burst_open = 1'b0;
               burst_left = '0;
               if (cnt == '0 || cnt > MAX_XFER) begin
                  owe_beat(STAT_BAD, '0, 1'b1);
               end else if (CNT_W'(cnt) > capacity_now - used_now) begin
                  owe_beat(STAT_FULL, '0, 1'b1);
               end else begin
                  burst_open = 1'b1;
                  burst_left = cnt;
                  store_byte(d);
                  owe_beat(STAT_OK, '0, 1'b1);
               end
            end else if (burst_open && burst_left != '0) begin
               store_byte(d);
               owe_beat(STAT_OK, '0, 1'b1);
            end else begin
               // stray byte or tail of a rejected burst
               owe_beat(STAT_BAD, '0, 1'b1);
            end
         end
         FUNC_CLEAR: begin
            empty_ring();
            owe_beat(STAT_OK, '0, 1'b1);
         end
         default: begin
            // retrieve and peek
            if (cnt == '0 || cnt > MAX_XFER) begin
               owe_beat(STAT_BAD, '0, 1'b1);
            end else if (CNT_W'(cnt) > used_now) begin
               owe_beat(STAT_EMPTY, '0, 1'b1);
            end else begin
               if (used_now <= write_pos) begin
                  rd = write_pos - used_now;
               end else begin
                  rd = capacity_now - (used_now - write_pos);
               end
               for (i = 0; i < int'(cnt); i++) begin
                  if (rd >= capacity_now) begin
                     rd = '0;
                  end
                  got[i] = ring_bytes[rd[IDX_W-1:0]];
                  rd = rd + 1'b1;
                  if (rd >= capacity_now) begin
                     rd = '0;
                  end
               end
               if (f == FUNC_RETRIEVE) begin
                  used_now = used_now - CNT_W'(cnt);
               end
               for (i = 0; i < int'(cnt); i++) begin
                  owe_beat(STAT_OK, got[i], i + 1 == int'(cnt));
               end
            end
         end
      endcase
   endtask

   // compare one accepted result beat with the oldest owed beat
   task automatic check_result();
      queue_beat_type want;
      if (expected_beats.size() == 0) begin
         report_mismatch($sformatf("result beat with nothing owed (status %0d byte %0h)",
                                   rsp_status, rsp_read_byte));
      end else begin
         want = expected_beats.pop_front();
         if (rsp_status !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
         end
         if (rsp_read_byte !== want.read_byte) begin
            report_mismatch($sformatf("read_byte got %0h want %0h", rsp_read_byte,
                                      want.read_byte));
         end
         if (rsp_last !== want.last) begin
            report_mismatch($sformatf("last got %0b want %0b", rsp_last, want.last));
         end
         if (rsp_used_count !== want.used_count) begin
            report_mismatch($sformatf("used_count got %0d want %0d", rsp_used_count,
                                      want.used_count));
         end
         if (rsp_free_count !== want.free_count) begin
            report_mismatch($sformatf("free_count got %0d want %0d", rsp_free_count,
                                      want.free_count));
         end
      end
   endtask

   // sample all three channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         capacity_now = CNT_W'(DEPTH);
         empty_ring();
         expected_beats.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            // capacity write: clamp to 1..DEPTH and start over empty
            if (csr_capacity == '0) begin
               capacity_now = CNT_W'(1);
            end else if (csr_capacity > DEPTH) begin
               capacity_now = CNT_W'(DEPTH);
            end else begin
               capacity_now = csr_capacity;
            end
            empty_ring();
         end
         if (req_valid && req_ready) begin
            apply_request(func_type'(req_func), req_count, req_data_byte, req_first);
         end
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
      end
      pending = expected_beats.size();
   end

endmodule

/* test/circular_byte_queue_tb.sv */
`timescale 1ns / 100ps
// Top of the circular byte queue testbench: clock, reset, request and capacity stimulus,
// result back-pressure and the verdict. Depends on cbq_pkg, circular_byte_queue and
// circular_byte_queue_checker.
module circular_byte_queue_tb;
   import cbq_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_func = FUNC_INSERT;
   logic [XFER_W-1:0]   req_count = '0;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                req_first = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic [BYTE_W-1:0]   rsp_read_byte;
   logic                rsp_last;
   logic [CNT_W-1:0]    rsp_used_count;
   logic [CNT_W-1:0]    rsp_free_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_capacity = '0;
   int                  mismatches;
   int                  pending;
   bit                  quiet = 1'b0;
   bit                  stall_request = 1'b0;

   always #4 clock = ~clock;

   circular_byte_queue dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_count      (req_count),
      .req_data_byte  (req_data_byte),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_last       (rsp_last),
      .rsp_used_count (rsp_used_count),
      .rsp_free_count (rsp_free_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity)
   );

   circular_byte_queue_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_count      (req_count),
      .req_data_byte  (req_data_byte),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_last       (rsp_last),
      .rsp_used_count (rsp_used_count),
      .rsp_free_count (rsp_free_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity),
      .mismatches     (mismatches),
      .pending        (pending)
   );

   initial begin : reset_gen
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin : result_sink
      int held;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ready <= 1'b0;
            for (held = 0; held < 200; held++) begin
               @(posedge clock);
            end
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 13);
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // present one request beat, with a random idle gap first when not quiet, and wait for its handshake
   task automatic send_item(input func_type f, input logic [XFER_W-1:0] cnt,
                            input logic [BYTE_W-1:0] d, input logic fst);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 13) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_count     <= cnt;
      req_data_byte <= d;
      req_first     <= fst;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_read(input func_type f, input int cnt);
      send_item(f, XFER_W'(cnt), BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // insert burst; a rough one may take reads, break off early or get a stray byte after
   task automatic send_burst(input int len, input bit rough);
      int i;
      int k;
      send_item(FUNC_INSERT, XFER_W'(len), BYTE_W'($urandom_range(0, 255)), 1'b1);
      for (i = 1; i < len; i++) begin
         if (rough) begin
            k = $urandom_range(0, 99);
            if (k < 3) begin
               return;
            end
            if (k < 10) begin
               send_read(($urandom_range(0, 1) != 0) ? FUNC_RETRIEVE : FUNC_PEEK,
                         $urandom_range(1, 3));
            end
         end
         send_item(FUNC_INSERT, XFER_W'($urandom_range(0, 127)),
                   BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
      if (rough && $urandom_range(0, 99) < 5) begin
         send_item(FUNC_INSERT, XFER_W'($urandom_range(0, 127)),
                   BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // stop offering and wait until every owed result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] v);
      drain();
      csr_valid    <= 1'b1;
      csr_capacity <= v;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed bursts with random content, plus reads, clears and noise
   task automatic random_phase(input int n);
      int sent;
      int pick;
      int r;
      int len;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(0, 99);
         r    = $urandom_range(0, 99);
         if (pick < 50) begin
            if (r < 80) begin
               len = $urandom_range(1, 6);
            end else if (r < 95) begin
               len = $urandom_range(7, 20);
            end else begin
               len = $urandom_range(21, 64);
            end
            send_burst(len, 1'b1);
            sent += len;
         end else if (pick < 80) begin
            if (r < 4) begin
               len = 0;
            end else if (r < 8) begin
               len = $urandom_range(65, 127);
            end else if (r < 13) begin
               len = 64;
            end else begin
               len = $urandom_range(1, 10);
            end
            send_read(($urandom_range(0, 1) != 0) ? FUNC_RETRIEVE : FUNC_PEEK, len);
            sent++;
         end else if (pick < 87) begin
            send_read(FUNC_CLEAR, $urandom_range(0, 127));
            sent++;
         end else if (pick < 94) begin
            send_item(FUNC_INSERT, XFER_W'($urandom_range(0, 127)),
                      BYTE_W'($urandom_range(0, 255)), 1'b0);
            sent++;
         end else begin
            len = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(65, 127);
            send_item(FUNC_INSERT, XFER_W'(len), BYTE_W'($urandom_range(0, 255)), 1'b1);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      wait (!reset);
      @(posedge clock);

      // empty queue, bad read lengths, stray byte, bad burst lengths
      send_item(FUNC_RETRIEVE, 7'd1, 8'h00, 1'b0);
      send_item(FUNC_PEEK, 7'd0, 8'h00, 1'b0);
      send_item(FUNC_RETRIEVE, 7'd127, 8'hFF, 1'b1);
      send_item(FUNC_INSERT, 7'd5, 8'h11, 1'b0);
      send_item(FUNC_INSERT, 7'd0, 8'h22, 1'b1);
      send_item(FUNC_INSERT, 7'd65, 8'h33, 1'b1);
      // three-byte burst with extreme bytes, one byte too many, then peek
      send_item(FUNC_INSERT, 7'd3, 8'h00, 1'b1);
      send_item(FUNC_INSERT, 7'd127, 8'hFF, 1'b0);
      send_item(FUNC_INSERT, 7'd0, 8'hA5, 1'b0);
      send_item(FUNC_INSERT, 7'd2, 8'h5A, 1'b0);
      send_item(FUNC_PEEK, 7'd3, 8'h00, 1'b0);
      // reads in the middle of an open burst
      send_item(FUNC_INSERT, 7'd4, 8'h01, 1'b1);
      send_item(FUNC_INSERT, 7'd0, 8'h02, 1'b0);
      send_item(FUNC_PEEK, 7'd5, 8'h00, 1'b0);
      send_item(FUNC_RETRIEVE, 7'd2, 8'h00, 1'b0);
      send_item(FUNC_INSERT, 7'd0, 8'h03, 1'b0);
      send_item(FUNC_INSERT, 7'd0, 8'h04, 1'b0);
      // a new first byte cuts the open burst short
      send_item(FUNC_INSERT, 7'd6, 8'h80, 1'b1);
      send_item(FUNC_INSERT, 7'd2, 8'h81, 1'b1);
      send_item(FUNC_INSERT, 7'd0, 8'h7F, 1'b0);
      // too few bytes stored, then read everything, clear and read again
      send_item(FUNC_RETRIEVE, 7'd64, 8'h00, 1'b0);
      send_item(FUNC_RETRIEVE, 7'd8, 8'h00, 1'b0);
      send_item(FUNC_CLEAR, 7'd0, 8'h00, 1'b0);
      send_item(FUNC_PEEK, 7'd1, 8'h00, 1'b0);

      // zero clamps to a one-byte ring: burst too large, its tail, then a fit
      write_capacity(11'd0);
      send_item(FUNC_INSERT, 7'd2, 8'hC3, 1'b1);
      send_item(FUNC_INSERT, 7'd0, 8'h3C, 1'b0);
      send_item(FUNC_INSERT, 7'd1, 8'h99, 1'b1);
      send_item(FUNC_INSERT, 7'd1, 8'h66, 1'b1);
      random_phase(6);

      // all ones clamps to full depth; hold results off while a long burst goes in
      write_capacity(11'd2047);
      stall_request = 1'b1;
      send_burst(24, 1'b0);
      send_read(FUNC_PEEK, 24);
      send_read(FUNC_RETRIEVE, 24);
      drain();
      random_phase(6);

      write_capacity(11'd3);
      random_phase(6);

      // back-to-back on both sides
      quiet = 1'b1;
      write_capacity(11'd64);
      random_phase(10);
      quiet = 1'b0;

      write_capacity(11'd1024);
      random_phase(6);

      write_capacity(11'd100);
      random_phase(6);

      write_capacity(11'd1025);
      random_phase(4);

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
